// File: design/joq_pkg.sv
// joq_pkg: shared types and constants of the job ownership queue.
// Used by joq_slot_mem, job_ownership_queue_unit and the bench; depends on nothing.
package joq_pkg;

  localparam int TOKEN_W             = 64;
  localparam int EPOCH_W             = 64;
  localparam int CAP_W               = 5;
  localparam int PEND_W              = 5;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 64'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_SUBMIT      = 3'd0,
    MODE_ACQUIRE     = 3'd1,
    MODE_COMPLETE    = 3'd2,
    MODE_PAUSE       = 3'd3,
    MODE_ABORT_PAUSE = 3'd4,
    MODE_RESUME      = 3'd5,
    MODE_FINISH_RST  = 3'd6,
    MODE_DEFER_RST   = 3'd7
  } joq_mode_t;

  typedef enum logic [3:0] {
    STS_OK          = 4'd0,
    STS_INVALID     = 4'd1,
    STS_BUSY        = 4'd2,
    STS_EXISTS      = 4'd3,
    STS_FULL        = 4'd4,
    STS_EMPTY       = 4'd5,
    STS_NO_ACTIVE   = 4'd6,
    STS_STALE       = 4'd7,
    STS_IN_PROGRESS = 4'd8
  } joq_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_ACQ  = 2'd2,
    ST_RESP = 2'd3
  } joq_state_t;

  // One queue slot as stored in the slot memory.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [TOKEN_W-1:0] token;
  } joq_slot_t;

endpackage

// File: design/joq_slot_mem.sv
// joq_slot_mem: single-port-write, single-port-read slot memory, read data
// registered and valid in the cycle after rd_en. Depends on joq_pkg.
module joq_slot_mem #(
  parameter int DEPTH = joq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  joq_pkg::joq_slot_t  wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output joq_pkg::joq_slot_t  rd_data
);
  import joq_pkg::*;

  joq_slot_t mem [DEPTH];
  joq_slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/job_ownership_queue_unit.sv
// job_ownership_queue_unit: bounded job FIFO with one active slot, epochs and
// admission control. Depends on joq_pkg and joq_slot_mem.
//
//  channel | ports                         | contents
//  --------+-------------------------------+---------------------------------
//  in      | in_tvalid/in_tready           | tuser: mode; tdata: token,
//          | in_tdata[135:0], in_tuser[2:0]| job_epoch, resume_after
//  out     | out_tvalid/out_tready         | tuser: status; tdata: out_token,
//          | out_tdata[135:0],out_tuser[3:0]| out_epoch, pending, accepting
//  cfg     | cfg_wr_en, cfg_wr_data[4:0]   | capacity, written when wr_en high
//
// One item at a time. A submit that reaches the duplicate scan reads one
// queued slot per cycle from the slot memory (one read port, pipelined so a
// compare overlaps the next read), then checks capacity and appends at the
// tail. A submit rejected up front skips the scan. An acquire that succeeds
// does one memory read; all other modes answer without the slot memory.
// Reset (rst_n low, synchronous) empties the queue, clears the active slot,
// sets epoch 1, opens admission and sets capacity 16. Slot contents are not
// cleared: only slots holding queued jobs are ever read.
// The result sits in an output register; the next item is accepted while it
// waits, and its own result waits in the engine until the register frees.
module job_ownership_queue_unit #(
  parameter int QUEUE_DEPTH = joq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  // slave side
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // [63:0] token, [127:64] job_epoch,
                                   // [128] resume_after, [135:129] zero
  input  logic [2:0]   in_tuser,   // [2:0] mode
  // master side
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [63:0] out_token, [127:64] out_epoch,
                                   // [132:128] pending, [133] accepting,
                                   // [135:134] zero
  output logic [3:0]   out_tuser,  // [3:0] status
  // configuration
  input  logic         cfg_wr_en,
  input  logic [joq_pkg::CAP_W-1:0] cfg_wr_data
);
  import joq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);
  localparam logic [CMP_W-1:0] CMP_DEPTH = CMP_W'(QUEUE_DEPTH);
  localparam logic [CMP_W-1:0] CMP_ONE   = CMP_W'(1);

  // ---------------- state registers ----------------
  joq_state_t          state_r,  state_nxt;
  logic [IDX_W-1:0]    head_r,   head_nxt;
  logic [CNT_W-1:0]    queued_r, queued_nxt;
  logic                act_vld_r, act_vld_nxt;
  logic [TOKEN_W-1:0]  act_tok_r, act_tok_nxt;
  logic [EPOCH_W-1:0]  act_ep_r,  act_ep_nxt;
  logic [EPOCH_W-1:0]  cur_ep_r,  cur_ep_nxt;
  logic                adm_r,     adm_nxt;
  logic                dfr_r,     dfr_nxt;
  logic                reopen_r,  reopen_nxt;
  logic [CAP_W-1:0]    cap_r;

  // scan engine
  logic [TOKEN_W-1:0]  op_tok_r,  op_tok_nxt;
  logic [IDX_W-1:0]    ptr_r,     ptr_nxt;
  logic [CNT_W-1:0]    issued_r,  issued_nxt;
  logic                rd_vld_r,  rd_vld_nxt;

  // pending result
  joq_status_t         res_sts_r, res_sts_nxt;
  logic [TOKEN_W-1:0]  res_tok_r, res_tok_nxt;
  logic [EPOCH_W-1:0]  res_ep_r,  res_ep_nxt;

  // output register
  logic                out_vld_r, out_vld_nxt;
  joq_status_t         out_sts_r;
  logic [TOKEN_W-1:0]  out_tok_r;
  logic [EPOCH_W-1:0]  out_ep_r;
  logic [PEND_W-1:0]   out_pend_r;
  logic                out_acc_r;
  logic                out_load;

  // slot memory ports
  logic                mem_wr_en;
  logic [IDX_W-1:0]    mem_wr_addr;
  joq_slot_t           mem_wr_data;
  logic                mem_rd_en;
  logic [IDX_W-1:0]    mem_rd_addr;
  joq_slot_t           mem_rd_data;

  // ---------------- input decode ----------------
  joq_mode_t           in_mode;
  logic [TOKEN_W-1:0]  in_token;
  logic [EPOCH_W-1:0]  in_epoch;
  logic                in_reopen;
  logic                in_fire;

  assign in_mode   = joq_mode_t'(in_tuser);
  assign in_token  = in_tdata[63:0];
  assign in_epoch  = in_tdata[127:64];
  assign in_reopen = in_tdata[128];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- derived values ----------------
  logic [CMP_W-1:0]    occ;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    eff_cap;
  logic                occ_zero;
  logic [EPOCH_W-1:0]  ep_bumped;
  logic [SUM_W-1:0]    tail_sum;
  logic [IDX_W-1:0]    tail_idx;
  logic [IDX_W-1:0]    head_inc;
  logic [IDX_W-1:0]    ptr_inc;

  assign occ      = CMP_W'(queued_r) + CMP_W'(act_vld_r);
  assign cap_ext  = CMP_W'(cap_r);
  // Zero acts as one; anything past the ring size acts as the ring size.
  assign eff_cap  = (cap_ext == '0) ? CMP_ONE :
                    ((cap_ext > CMP_DEPTH) ? CMP_DEPTH : cap_ext);
  assign occ_zero = (occ == '0);
  // Epoch counts 1..max and wraps back to 1, never 0.
  assign ep_bumped = (cur_ep_r == EPOCH_MAX) ? EPOCH_RESET : cur_ep_r + EPOCH_RESET;

  // Tail index: head + queued stays below twice the ring size.
  assign tail_sum = SUM_W'(head_r) + SUM_W'(queued_r);
  assign tail_idx = (tail_sum >= SUM_DEPTH) ? IDX_W'(tail_sum - SUM_DEPTH)
                                            : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
  assign ptr_inc  = (ptr_r  == IDX_LAST) ? '0 : ptr_r  + IDX_W'(1);

  // ---------------- control ----------------
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    queued_nxt  = queued_r;
    act_vld_nxt = act_vld_r;
    act_tok_nxt = act_tok_r;
    act_ep_nxt  = act_ep_r;
    cur_ep_nxt  = cur_ep_r;
    adm_nxt     = adm_r;
    dfr_nxt     = dfr_r;
    reopen_nxt  = reopen_r;
    op_tok_nxt  = op_tok_r;
    ptr_nxt     = ptr_r;
    issued_nxt  = issued_r;
    rd_vld_nxt  = 1'b0;
    res_sts_nxt = res_sts_r;
    res_tok_nxt = res_tok_r;
    res_ep_nxt  = res_ep_r;
    out_load    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = tail_idx;
    mem_wr_data = '{epoch: cur_ep_r, token: op_tok_r};
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_tok_nxt  = in_token;
          res_sts_nxt = STS_OK;
          res_tok_nxt = '0;
          res_ep_nxt  = '0;
          state_nxt   = ST_RESP;
          case (in_mode)
            MODE_SUBMIT: begin
              if (in_token == '0) begin
                res_sts_nxt = STS_INVALID;
              end else if (!adm_r) begin
                res_sts_nxt = STS_BUSY;
              end else if (act_vld_r && act_tok_r == in_token) begin
                res_sts_nxt = STS_EXISTS;
              end else begin
                // walk the queued slots from the head
                ptr_nxt    = head_r;
                issued_nxt = '0;
                state_nxt  = ST_SCAN;
              end
            end
            MODE_ACQUIRE: begin
              if (act_vld_r) begin
                res_sts_nxt = STS_BUSY;
              end else if (queued_r == '0) begin
                res_sts_nxt = STS_EMPTY;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = head_r;
                state_nxt   = ST_ACQ;
              end
            end
            MODE_COMPLETE: begin
              if (in_token == '0 || in_epoch == '0) begin
                res_sts_nxt = STS_INVALID;
              end else if (!act_vld_r) begin
                res_sts_nxt = STS_NO_ACTIVE;
              end else if (in_token != act_tok_r || in_epoch != act_ep_r) begin
                res_sts_nxt = STS_STALE;
              end else begin
                act_vld_nxt = 1'b0;
                act_tok_nxt = '0;
                act_ep_nxt  = '0;
                // deferred reset lands once everything has drained
                if (dfr_r && queued_r == '0) begin
                  cur_ep_nxt = ep_bumped;
                  adm_nxt    = reopen_r;
                  dfr_nxt    = 1'b0;
                  reopen_nxt = 1'b0;
                end
              end
            end
            MODE_PAUSE: begin
              adm_nxt     = 1'b0;
              res_sts_nxt = occ_zero ? STS_OK : STS_IN_PROGRESS;
            end
            MODE_ABORT_PAUSE: begin
              if (dfr_r) begin
                res_sts_nxt = STS_BUSY;
              end else begin
                adm_nxt = 1'b1;
              end
            end
            MODE_RESUME: begin
              if (!occ_zero || dfr_r) begin
                res_sts_nxt = STS_BUSY;
              end else begin
                adm_nxt = 1'b1;
              end
            end
            MODE_FINISH_RST: begin
              if (adm_r || !occ_zero || dfr_r) begin
                res_sts_nxt = STS_BUSY;
              end else begin
                cur_ep_nxt = ep_bumped;
                adm_nxt    = in_reopen;
                dfr_nxt    = 1'b0;
                reopen_nxt = 1'b0;
              end
            end
            MODE_DEFER_RST: begin
              if (adm_r || dfr_r) begin
                res_sts_nxt = STS_BUSY;
              end else if (occ_zero) begin
                cur_ep_nxt = ep_bumped;
                adm_nxt    = in_reopen;
                dfr_nxt    = 1'b0;
                reopen_nxt = 1'b0;
              end else begin
                dfr_nxt    = 1'b1;
                reopen_nxt = in_reopen;
              end
            end
            default: begin
              res_sts_nxt = STS_BUSY;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_vld_r && mem_rd_data.token == op_tok_r) begin
          res_sts_nxt = STS_EXISTS;
          state_nxt   = ST_RESP;
        end else if (issued_r == queued_r && !rd_vld_r) begin
          // no duplicate: capacity check, then append at the tail
          if (occ >= eff_cap) begin
            res_sts_nxt = STS_FULL;
          end else begin
            mem_wr_en   = 1'b1;
            queued_nxt  = queued_r + CNT_W'(1);
            res_sts_nxt = STS_OK;
            res_ep_nxt  = cur_ep_r;
          end
          state_nxt = ST_RESP;
        end else if (issued_r != queued_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_r;
          ptr_nxt     = ptr_inc;
          issued_nxt  = issued_r + CNT_W'(1);
          rd_vld_nxt  = 1'b1;
        end
      end

      ST_ACQ: begin
        act_vld_nxt = 1'b1;
        act_tok_nxt = mem_rd_data.token;
        act_ep_nxt  = mem_rd_data.epoch;
        head_nxt    = head_inc;
        queued_nxt  = queued_r - CNT_W'(1);
        res_sts_nxt = STS_OK;
        res_tok_nxt = mem_rd_data.token;
        res_ep_nxt  = mem_rd_data.epoch;
        state_nxt   = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_vld_nxt = out_load || (out_vld_r && !out_tready);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      head_r    <= '0;
      queued_r  <= '0;
      act_vld_r <= 1'b0;
      act_tok_r <= '0;
      act_ep_r  <= '0;
      cur_ep_r  <= EPOCH_RESET;
      adm_r     <= 1'b1;
      dfr_r     <= 1'b0;
      reopen_r  <= 1'b0;
      cap_r     <= CAP_RESET;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      queued_r  <= queued_nxt;
      act_vld_r <= act_vld_nxt;
      act_tok_r <= act_tok_nxt;
      act_ep_r  <= act_ep_nxt;
      cur_ep_r  <= cur_ep_nxt;
      adm_r     <= adm_nxt;
      dfr_r     <= dfr_nxt;
      reopen_r  <= reopen_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    op_tok_r  <= op_tok_nxt;
    ptr_r     <= ptr_nxt;
    issued_r  <= issued_nxt;
    res_sts_r <= res_sts_nxt;
    res_tok_r <= res_tok_nxt;
    res_ep_r  <= res_ep_nxt;
    if (out_load) begin
      // state is final by now; pending/accepting reflect the post-op view
      out_sts_r  <= res_sts_r;
      out_tok_r  <= res_tok_r;
      out_ep_r   <= res_ep_r;
      out_pend_r <= occ[PEND_W-1:0];
      out_acc_r  <= adm_r;
    end
  end

  // Writes happen only at the end of a submit, after its scan reads; acquire
  // reads in a later item, so no read overlaps a write to the same slot.
  joq_slot_mem #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // ---------------- outputs ----------------
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_sts_r;
  assign out_tdata  = {2'b00, out_acc_r, out_pend_r, out_ep_r, out_tok_r};

  // ---------------- assertions ----------------
  a_queued_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queued_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queued count exceeds ring size");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_ep_r != '0)
    else $error("current epoch is zero");

  a_defer_closed: assert property (@(posedge clk) disable iff (!rst_n)
    dfr_r |-> !adm_r)
    else $error("admission open while a reset is deferred");

  a_acq_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACQ) |-> (!act_vld_r && queued_r != '0))
    else $error("acquire read with active job or empty queue");

endmodule

// File: tb/tb_job_ownership_queue_unit.sv
// tb_job_ownership_queue_unit: self-checking bench for the job ownership queue.
// A directed table and a stream of random jobs are checked against an in-bench
// model of the queue. Depends on joq_pkg and job_ownership_queue_unit.
module tb_job_ownership_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import joq_pkg::*;

  localparam int QDEPTH         = DEFAULT_QUEUE_DEPTH;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 208;
  localparam int STALL_LIMIT    = 3000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 40;
  localparam logic [63:0] TOK_MAX = {64{1'b1}};

  // capacity per random phase: 0 acts as 1, 31 acts as QDEPTH
  localparam logic [CAP_W-1:0] CAP_STEPS [PHASES] = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd3, 5'd7};

  // one result item as seen on the master side
  typedef struct packed {
    joq_status_t   status;
    logic [63:0]   tok;
    logic [63:0]   ep;
    logic [4:0]    pend;
    logic          acc;
  } job_result_t;

  // directed row: pinned rows carry a hand-written result, others use the model
  typedef struct packed {
    joq_mode_t     mode;
    logic [63:0]   tok;
    logic [63:0]   ep;
    logic          reopen;
    logic          pinned;
    job_result_t   want;
  } dir_row_t;

  localparam job_result_t NONE = '{STS_OK, 64'd0, 64'd0, 5'd0, 1'b0};

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // empty queue after reset: error codes
    '{MODE_SUBMIT,      64'd0,   64'd0, 1'b0, 1'b1, '{STS_INVALID,   64'd0, 64'd0, 5'd0, 1'b1}},
    '{MODE_ACQUIRE,     64'd0,   64'd0, 1'b0, 1'b1, '{STS_EMPTY,     64'd0, 64'd0, 5'd0, 1'b1}},
    '{MODE_COMPLETE,    64'd5,   64'd1, 1'b0, 1'b1, '{STS_NO_ACTIVE, 64'd0, 64'd0, 5'd0, 1'b1}},
    '{MODE_COMPLETE,    64'd0,   64'd1, 1'b0, 1'b1, '{STS_INVALID,   64'd0, 64'd0, 5'd0, 1'b1}},
    '{MODE_COMPLETE,    64'd5,   64'd0, 1'b0, 1'b1, '{STS_INVALID,   64'd0, 64'd0, 5'd0, 1'b1}},
    // largest token, then a duplicate of it
    '{MODE_SUBMIT,      TOK_MAX, 64'd0, 1'b0, 1'b1, '{STS_OK,        64'd0, 64'd1, 5'd1, 1'b1}},
    '{MODE_SUBMIT,      TOK_MAX, 64'd0, 1'b0, 1'b1, '{STS_EXISTS,    64'd0, 64'd0, 5'd1, 1'b1}},
    '{MODE_SUBMIT,      64'd1,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_ACQUIRE,     64'd0,   64'd0, 1'b0, 1'b0, NONE},
    // stale completions: wrong epoch, wrong token
    '{MODE_COMPLETE,    TOK_MAX, 64'd2, 1'b0, 1'b0, NONE},
    '{MODE_COMPLETE,    64'd1,   64'd1, 1'b0, 1'b0, NONE},
    '{MODE_RESUME,      64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_PAUSE,       64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_ABORT_PAUSE, 64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_PAUSE,       64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_FINISH_RST,  64'd0,   64'd0, 1'b1, 1'b0, NONE},
    // reset deferred while jobs are owned, applied by the last complete
    '{MODE_DEFER_RST,   64'd0,   64'd0, 1'b1, 1'b0, NONE},
    '{MODE_ABORT_PAUSE, 64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_DEFER_RST,   64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_COMPLETE,    TOK_MAX, 64'd1, 1'b0, 1'b0, NONE},
    '{MODE_ACQUIRE,     64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_COMPLETE,    64'd1,   64'd1, 1'b0, 1'b0, NONE},
    // idle reset paths: finish closed, defer applied at once
    '{MODE_PAUSE,       64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_FINISH_RST,  64'd0,   64'd0, 1'b0, 1'b0, NONE},
    '{MODE_DEFER_RST,   TOK_MAX, TOK_MAX, 1'b1, 1'b0, NONE}
  };

  // DUT ports; every bench-driven input known from time zero
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [135:0]        in_tdata    = '0;  // [63:0] token, [127:64] job_epoch, [128] resume_after
  logic [2:0]          in_tuser    = '0;  // [2:0] mode
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [135:0]        out_tdata;         // [63:0] token, [127:64] epoch, [132:128] pending,
                                          // [133] accepting
  logic [3:0]          out_tuser;         // [3:0] status
  logic                cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data = '0;

  // bench-side copy of the queue state, reset values
  logic [63:0]      q_tok [QDEPTH];
  logic [63:0]      q_ep  [QDEPTH];
  logic [3:0]       q_head      = '0;
  int               q_cnt       = 0;
  logic [63:0]      act_tok     = '0;
  logic [63:0]      act_ep      = '0;
  logic             act_vld     = 1'b0;
  logic [63:0]      cur_epoch   = EPOCH_RESET;
  logic             adm_open    = 1'b1;
  logic             rst_defer   = 1'b0;
  logic             rst_reopen  = 1'b0;
  logic [CAP_W-1:0] cap_reg     = CAP_RESET;

  job_result_t awaited_results [$];  // results owed by the DUT, oldest first
  int          err_count     = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  job_ownership_queue_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // epoch bump; the maximum wraps to 1
  function automatic void apply_epoch_reset(logic reopen);
    cur_epoch  = (cur_epoch == EPOCH_MAX) ? 64'd1 : cur_epoch + 64'd1;
    adm_open   = reopen;
    rst_defer  = 1'b0;
    rst_reopen = 1'b0;
  endfunction

  // Applies one accepted item to the bench state and returns the result owed.
  function automatic job_result_t owner_step(joq_mode_t m, logic [63:0] tok,
                                             logic [63:0] ep, logic reopen);
    job_result_t r;
    logic        owned;
    logic [3:0]  tail;
    int          occ;
    int          lim;
    r     = NONE;
    occ   = q_cnt + int'(act_vld);
    lim   = (cap_reg == 0) ? 1 : ((int'(cap_reg) > QDEPTH) ? QDEPTH : int'(cap_reg));
    case (m)
      MODE_SUBMIT: begin
        owned = act_vld && (act_tok == tok);
        for (int i = 0; i < q_cnt; i++) begin
          if (q_tok[4'(int'(q_head) + i)] == tok) owned = 1'b1;
        end
        if (tok == 0) r.status = STS_INVALID;
        else if (!adm_open) r.status = STS_BUSY;
        else if (owned) r.status = STS_EXISTS;
        else if (occ >= lim) r.status = STS_FULL;  // also when capacity dropped below occupancy
        else begin
          tail        = 4'(int'(q_head) + q_cnt);   // ring index independent of capacity
          q_tok[tail] = tok;
          q_ep[tail]  = cur_epoch;
          q_cnt++;
          r.ep = cur_epoch;
        end
      end
      MODE_ACQUIRE: begin
        if (act_vld) r.status = STS_BUSY;
        else if (q_cnt == 0) r.status = STS_EMPTY;
        else begin
          act_tok = q_tok[q_head];
          act_ep  = q_ep[q_head];
          act_vld = 1'b1;
          q_head++;
          q_cnt--;
          r.tok = act_tok;
          r.ep  = act_ep;
        end
      end
      MODE_COMPLETE: begin
        if (tok == 0 || ep == 0) r.status = STS_INVALID;
        else if (!act_vld) r.status = STS_NO_ACTIVE;
        else if (tok != act_tok || ep != act_ep) r.status = STS_STALE;
        else begin
          act_tok = '0;
          act_ep  = '0;
          act_vld = 1'b0;
          if (rst_defer && q_cnt == 0) apply_epoch_reset(rst_reopen);
        end
      end
      MODE_PAUSE: begin
        adm_open = 1'b0;
        r.status = (occ == 0) ? STS_OK : STS_IN_PROGRESS;
      end
      MODE_ABORT_PAUSE: begin
        if (rst_defer) r.status = STS_BUSY;
        else adm_open = 1'b1;
      end
      MODE_RESUME: begin
        if (occ != 0 || rst_defer) r.status = STS_BUSY;
        else adm_open = 1'b1;
      end
      MODE_FINISH_RST: begin
        if (adm_open || occ != 0 || rst_defer) r.status = STS_BUSY;
        else apply_epoch_reset(reopen);
      end
      default: begin
        if (adm_open || rst_defer) r.status = STS_BUSY;
        else if (occ == 0) apply_epoch_reset(reopen);
        else begin
          rst_defer  = 1'b1;
          rst_reopen = reopen;
        end
      end
    endcase
    r.pend = 5'(q_cnt + int'(act_vld));
    r.acc  = adm_open;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // Present one item, hold it until accepted, then book its result.
  // Idle cycles only fall between items; tvalid never drops while waiting.
  task automatic issue(joq_mode_t m, logic [63:0] tok, logic [63:0] ep, logic reopen,
                       logic pinned, job_result_t want);
    job_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {7'd0, reopen, ep, tok};
    do @(posedge clk); while (!in_tready);
    pred = owner_step(m, tok, ep, reopen);
    awaited_results.push_back(pinned ? want : pred);
  endtask

  // receiver stalls at random, per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted result with the oldest one owed
  always @(posedge clk) begin : result_check
    job_result_t got;
    job_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = joq_status_t'(out_tuser);
      got.tok    = out_tdata[63:0];
      got.ep     = out_tdata[127:64];
      got.pend   = out_tdata[132:128];
      got.acc    = out_tdata[133];
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing owed (token)", got.tok, 64'd0);
      end else begin
        want = awaited_results.pop_front();
        if (got.status != want.status) report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.tok != want.tok) report_mismatch("token", got.tok, want.tok);
        if (got.ep != want.ep) report_mismatch("epoch", got.ep, want.ep);
        if (got.pend != want.pend) report_mismatch("pending", 64'(got.pend), 64'(want.pend));
        if (got.acc != want.acc) report_mismatch("accepting", 64'(got.acc), 64'(want.acc));
      end
    end
  end

  // hang detector: too long without any handshake ends the run
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_job_ownership_queue_unit: FAIL");
    $finish;
  end

  initial begin : stimulus
    joq_mode_t   m;
    logic [63:0] tok;
    logic [63:0] ep;
    logic        ro;
    int          pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs on the reset capacity, slow receiver
    send_idle_pct = 11;
    recv_idle_pct = 82;
    for (int i = 0; i < DIR_ROWS; i++) begin
      issue(DIR_TAB[i].mode, DIR_TAB[i].tok, DIR_TAB[i].ep, DIR_TAB[i].reopen,
            DIR_TAB[i].pinned, DIR_TAB[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      // drain, then change capacity while idle; owned jobs stay queued
      in_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= CAP_STEPS[p];
      @(posedge clk);
      cfg_wr_en   <= 1'b0;
      cap_reg      = CAP_STEPS[p];

      send_idle_pct = (p < 2) ? 11 : ((p < 4) ? 82 : 0);
      recv_idle_pct = (p < 2) ? 82 : ((p < 4) ? 11 : 0);

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        ro   = 1'($urandom_range(1));
        ep   = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        tok  = ($urandom_range(6) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1, 40));
        if (!adm_open && !rst_defer && (q_cnt + int'(act_vld)) == 0 && pick < 50) begin
          // closed and empty: mostly reopen or run a reset
          m = (pick < 20) ? MODE_RESUME : ((pick < 35) ? MODE_FINISH_RST : MODE_DEFER_RST);
        end else if (pick < 36) begin
          m = MODE_SUBMIT;
          if ($urandom_range(24) == 0) tok = '0;
        end else if (pick < 56) begin
          m = MODE_ACQUIRE;
        end else if (pick < 80) begin
          m = MODE_COMPLETE;
          if (act_vld && $urandom_range(9) < 8) begin
            tok = act_tok;
            ep  = act_ep;
            if ($urandom_range(9) == 0) ep = ep ^ (64'd1 << $urandom_range(63));
          end else begin
            pick = $urandom_range(2);
            ep   = (pick == 0) ? cur_epoch : ((pick == 1) ? {$urandom, $urandom} : 64'd0);
          end
        end else if (pick < 84) begin
          m = MODE_PAUSE;
        end else if (pick < 89) begin
          m = MODE_ABORT_PAUSE;
        end else if (pick < 93) begin
          m = MODE_RESUME;
        end else if (pick < 96) begin
          m = MODE_FINISH_RST;
        end else begin
          m = MODE_DEFER_RST;
        end
        issue(m, tok, ep, ro, 1'b0, NONE);
      end
    end

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("tb_job_ownership_queue_unit: PASS");
    end else begin
      if (awaited_results.size() != 0)
        report_mismatch("results still owed at end", 64'(awaited_results.size()), 64'd0);
      $display("tb_job_ownership_queue_unit: FAIL");
    end
    $finish;
  end

endmodule
